@@ design/mpm_pkg.sv @@
// Shared pixel type, mode and register codes, and the radar palette of the pseudo-color mapper.
`timescale 1ns / 1ps
`default_nettype none

package mpm_pkg;

	// One RGBA pixel, packed so that red sits in the lowest byte.
	typedef struct packed {
		logic [7:0] alpha;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} pixel_t;

	// Mapping modes held in the mode register.
	localparam logic [2:0] MODE_SAT   = 3'd0;
	localparam logic [2:0] MODE_RADAR = 3'd1;
	localparam logic [2:0] MODE_PRCP  = 3'd2;
	localparam logic [2:0] MODE_TEMP  = 3'd3;
	localparam logic [2:0] MODE_WIND  = 3'd4;
	localparam logic [2:0] MODE_GRAY  = 3'd5;

	// Configuration register indexes.
	localparam logic REG_MAP_MODE   = 1'b0;
	localparam logic REG_SAT_OFFSET = 1'b1;

	// The satellite offset comes out of reset at 273.15 with eight fraction bits.
	localparam logic [23:0] SAT_OFFSET_RESET = 24'd69926;

	// Radar codes from RADAR_BASE up to RADAR_TOP select a band; band 0 and codes outside it are clear.
	localparam logic [7:0] RADAR_BASE = 8'd66;
	localparam logic [7:0] RADAR_TOP  = 8'd215;

	localparam pixel_t CLEAR_BLACK = '{alpha: 8'd0, blue: 8'd0, green: 8'd0, red: 8'd0};
	localparam pixel_t CLEAR_WHITE = '{alpha: 8'd0, blue: 8'd255, green: 8'd255, red: 8'd255};

	function automatic pixel_t rgba(input logic [7:0] r, input logic [7:0] g,
		input logic [7:0] b, input logic [7:0] a);
		pixel_t p;
		p.red   = r;
		p.green = g;
		p.blue  = b;
		p.alpha = a;
		return p;
	endfunction

	// Fourteen colored radar reflectivity bands, ten codes wide each; other indexes give clear black.
	function automatic pixel_t radar_color(input logic [3:0] idx);
		pixel_t p;
		unique case (idx)
			4'd1:    p = rgba(8'd122, 8'd114, 8'd239, 8'd255);
			4'd2:    p = rgba(8'd30,  8'd38,  8'd209, 8'd255);
			4'd3:    p = rgba(8'd165, 8'd253, 8'd167, 8'd255);
			4'd4:    p = rgba(8'd0,   8'd235, 8'd0,   8'd255);
			4'd5:    p = rgba(8'd16,  8'd147, 8'd26,  8'd255);
			4'd6:    p = rgba(8'd253, 8'd245, 8'd100, 8'd255);
			4'd7:    p = rgba(8'd199, 8'd200, 8'd2,   8'd255);
			4'd8:    p = rgba(8'd141, 8'd141, 8'd0,   8'd255);
			4'd9:    p = rgba(8'd255, 8'd173, 8'd173, 8'd255);
			4'd10:   p = rgba(8'd255, 8'd100, 8'd92,  8'd255);
			4'd11:   p = rgba(8'd239, 8'd2,   8'd48,  8'd255);
			4'd12:   p = rgba(8'd213, 8'd143, 8'd255, 8'd255);
			4'd13:   p = rgba(8'd171, 8'd36,  8'd251, 8'd255);
			4'd14:   p = rgba(8'd131, 8'd20,  8'd80,  8'd255);
			default: p = CLEAR_BLACK;
		endcase
		return p;
	endfunction

endpackage

`default_nettype wire

@@ design/meteo_pseudocolor_mapper_core.sv @@
// Top level of the pseudo-color mapper: a three-stage pipeline from sample to RGBA pixel.
//
// The input stream carries one grid sample per request: a signed fixed-point value
// with FRAC_BITS fraction bits and a raw radar code. The output stream returns one
// RGBA pixel per request, colored by the mode register (satellite ramps, radar
// palette, precipitation, temperature and wind thresholds, or gray).
// The configuration port writes the mode and the satellite offset; the user must make writes
// only while no request is in flight, as the block does not enforce this.
// A request passes through the stage-one, stage-two and output registers in order; a new
// request is taken every cycle while the output does not stall. Stage one forms the
// offset difference, the Kelvin difference and the gray magnitude; stage two finds the
// band and its local offset, looks up the threshold palettes and folds the gray value
// modulo 255; stage three applies the ramp multipliers and selects the final pixel into
// the output register.
// Each stage has its own valid bit and moves whenever the stage after it is free, so
// a stall on the output fills bubbles first and then holds everything in place.
// Reset clears the valid bits and loads the mode and offset registers with their
// defaults; the pipeline is empty after reset.
`timescale 1ns / 1ps
`default_nettype none

module meteo_pseudocolor_mapper_core #(
	parameter int FRAC_BITS = 8
) (
	input  wire         clk,
	input  wire         arst_n,
	// Input stream. tdata: sample [23:0], radar_byte [31:24].
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [31:0] s_axis_tdata,
	// Output stream. tdata: red [7:0], green [15:8], blue [23:16], alpha [31:24].
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [31:0] m_axis_tdata,
	// Configuration write port.
	input  wire         cfg_we,
	input  wire         cfg_index,
	input  wire  [23:0] cfg_data
);
	import mpm_pkg::*;

	localparam int SC = 1 << FRAC_BITS;
	// Width of the magnitude of the integer part of a 24-bit sample.
	localparam int IW = 24 - FRAC_BITS;
	// Offset inside a satellite band stays below 64 units; ramp products below 256.
	localparam int EW = FRAC_BITS + 6;
	localparam int PW = FRAC_BITS + 8;

	localparam logic signed [24:0] KELVIN_FX = 25'((27315 * SC + 50) / 100);
	localparam logic signed [24:0] RAIN_MIN  = 25'((11 * SC + 50) / 100);

	// Satellite band edges.
	localparam logic signed [24:0] D_M100 = 25'(-100 * SC);
	localparam logic signed [24:0] D_M90  = 25'(-90 * SC);
	localparam logic signed [24:0] D_M80  = 25'(-80 * SC);
	localparam logic signed [24:0] D_M70  = 25'(-70 * SC);
	localparam logic signed [24:0] D_M60  = 25'(-60 * SC);
	localparam logic signed [24:0] D_M50  = 25'(-50 * SC);
	localparam logic signed [24:0] D_M30  = 25'(-30 * SC);
	localparam logic signed [24:0] D_P20  = 25'(20 * SC);

	// Generic integer thresholds, used by several palettes.
	localparam logic signed [24:0] T_M20 = 25'(-20 * SC);
	localparam logic signed [24:0] T_M15 = 25'(-15 * SC);
	localparam logic signed [24:0] T_M10 = 25'(-10 * SC);
	localparam logic signed [24:0] T_M5  = 25'(-5 * SC);
	localparam logic signed [24:0] T_4   = 25'(4 * SC);
	localparam logic signed [24:0] T_5   = 25'(5 * SC);
	localparam logic signed [24:0] T_6   = 25'(6 * SC);
	localparam logic signed [24:0] T_8   = 25'(8 * SC);
	localparam logic signed [24:0] T_10  = 25'(10 * SC);
	localparam logic signed [24:0] T_12  = 25'(12 * SC);
	localparam logic signed [24:0] T_14  = 25'(14 * SC);
	localparam logic signed [24:0] T_15  = 25'(15 * SC);
	localparam logic signed [24:0] T_18  = 25'(18 * SC);
	localparam logic signed [24:0] T_20  = 25'(20 * SC);
	localparam logic signed [24:0] T_21  = 25'(21 * SC);
	localparam logic signed [24:0] T_25  = 25'(25 * SC);
	localparam logic signed [24:0] T_29  = 25'(29 * SC);
	localparam logic signed [24:0] T_30  = 25'(30 * SC);
	localparam logic signed [24:0] T_33  = 25'(33 * SC);
	localparam logic signed [24:0] T_35  = 25'(35 * SC);
	localparam logic signed [24:0] T_37  = 25'(37 * SC);
	localparam logic signed [24:0] T_50  = 25'(50 * SC);
	localparam logic signed [24:0] T_100 = 25'(100 * SC);
	localparam logic signed [24:0] T_250 = 25'(250 * SC);
	localparam logic signed [24:0] T_255 = 25'(255 * SC);
	localparam logic signed [24:0] T_500 = 25'(500 * SC);

	// Ramp constants at product width.
	localparam logic [PW-1:0] K100 = PW'(100 * SC);
	localparam logic [PW-1:0] K255 = PW'(255 * SC);

	typedef enum logic [2:0] {
		SB_NONE,
		SB_DARK,
		SB_RISE,
		SB_RED,
		SB_GREEN,
		SB_BLUE,
		SB_CYAN,
		SB_FADE
	} sat_band_t;

	// Configuration registers.
	logic [2:0]  map_mode_q;
	logic [23:0] sat_offset_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_mode_q   <= MODE_SAT;
			sat_offset_q <= SAT_OFFSET_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MAP_MODE:   map_mode_q   <= cfg_data[2:0];
				REG_SAT_OFFSET: sat_offset_q <= cfg_data;
				default:        ;
			endcase
		end
	end

	// Per-stage flow control: a stage moves when it is empty or its successor moves.
	logic v_s1, v_s2, v_s3;
	logic rdy1, rdy2, rdy3;

	assign rdy3          = !v_s3 || m_axis_tready;
	assign rdy2          = !v_s2 || rdy3;
	assign rdy1          = !v_s1 || rdy2;
	assign s_axis_tready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= s_axis_tvalid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
		end
	end

	// Stage one: differences and gray magnitude.
	logic signed [24:0] sx_in, off_in, d_in, t_in;
	logic [24:0]        mag_in;
	logic [IW-1:0]      absi_in;
	logic               direct_in;

	assign sx_in     = signed'({s_axis_tdata[23], s_axis_tdata[23:0]});
	assign off_in    = signed'({sat_offset_q[23], sat_offset_q});
	assign d_in      = sx_in - off_in;
	assign t_in      = sx_in - KELVIN_FX;
	assign mag_in    = sx_in[24] ? 25'(25'sd0 - sx_in) : 25'(sx_in);
	assign absi_in   = IW'(mag_in >> FRAC_BITS);
	assign direct_in = !sx_in[24] && (sx_in <= T_255);

	logic signed [24:0] d_s1, t_s1, sx_s1;
	logic [7:0]         byte_s1;
	logic [2:0]         mode_s1;
	logic [IW-1:0]      absi_s1;
	logic               neg_s1, direct_s1;

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && rdy1) begin
			d_s1      <= d_in;
			t_s1      <= t_in;
			sx_s1     <= sx_in;
			byte_s1   <= s_axis_tdata[31:24];
			mode_s1   <= map_mode_q;
			absi_s1   <= absi_in;
			neg_s1    <= sx_in[24];
			direct_s1 <= direct_in;
		end
	end

	// Stage two: satellite band and offset within it.
	sat_band_t          band_c;
	logic signed [24:0] base_c, efull_c;

	always_comb begin
		band_c = SB_NONE;
		base_c = 25'sd0;
		if (d_s1 < D_M100) begin
			band_c = SB_NONE;
		end else if (d_s1 < D_M90) begin
			band_c = SB_DARK;
			base_c = -D_M100;
		end else if (d_s1 < D_M80) begin
			band_c = SB_RISE;
			base_c = -D_M90;
		end else if (d_s1 < D_M70) begin
			band_c = SB_RED;
			base_c = -D_M80;
		end else if (d_s1 < D_M60) begin
			band_c = SB_GREEN;
			base_c = -D_M70;
		end else if (d_s1 < D_M50) begin
			band_c = SB_BLUE;
			base_c = -D_M60;
		end else if (d_s1 < D_M30) begin
			band_c = SB_CYAN;
			base_c = -D_M50;
		end else if (d_s1 < D_P20) begin
			band_c = SB_FADE;
			base_c = -D_M30;
		end
	end

	assign efull_c = d_s1 + base_c;

	// Stage two: radar band index, (code - 66) / 10 by reciprocal multiply.
	logic [7:0]  rdiff_c;
	logic [15:0] rprod_c;
	logic [3:0]  ridx_c;

	assign rdiff_c = byte_s1 - RADAR_BASE;
	assign rprod_c = 16'(rdiff_c) * 16'd205;
	assign ridx_c  = (byte_s1 >= RADAR_BASE && byte_s1 <= RADAR_TOP) ? rprod_c[14:11] : 4'd0;

	// Stage two: threshold palettes.
	pixel_t prcp_c, temp_c, wind_c, pal_c;

	always_comb begin
		if (sx_s1 < RAIN_MIN)   prcp_c = CLEAR_WHITE;
		else if (sx_s1 < T_10)  prcp_c = rgba(8'd170, 8'd240, 8'd144, 8'd255);
		else if (sx_s1 < T_25)  prcp_c = rgba(8'd61,  8'd183, 8'd64,  8'd255);
		else if (sx_s1 < T_50)  prcp_c = rgba(8'd93,  8'd182, 8'd255, 8'd255);
		else if (sx_s1 < T_100) prcp_c = rgba(8'd1,   8'd1,   8'd219, 8'd255);
		else if (sx_s1 < T_250) prcp_c = rgba(8'd253, 8'd1,   8'd246, 8'd255);
		else if (sx_s1 < T_500) prcp_c = rgba(8'd129, 8'd1,   8'd65,  8'd255);
		else                    prcp_c = CLEAR_WHITE;
	end

	always_comb begin
		if (t_s1 < T_M20)      temp_c = rgba(8'd0,   8'd0,   8'd254, 8'd255);
		else if (t_s1 < T_M15) temp_c = rgba(8'd0,   8'd128, 8'd255, 8'd255);
		else if (t_s1 < T_M10) temp_c = rgba(8'd0,   8'd225, 8'd255, 8'd255);
		else if (t_s1 < T_M5)  temp_c = rgba(8'd0,   8'd255, 8'd208, 8'd255);
		else if (t_s1[24])     temp_c = rgba(8'd0,   8'd255, 8'd149, 8'd255);
		else if (t_s1 < T_5)   temp_c = rgba(8'd0,   8'd255, 8'd109, 8'd255);
		else if (t_s1 < T_10)  temp_c = rgba(8'd0,   8'd255, 8'd17,  8'd255);
		else if (t_s1 < T_15)  temp_c = rgba(8'd118, 8'd255, 8'd0,   8'd255);
		else if (t_s1 < T_20)  temp_c = rgba(8'd172, 8'd255, 8'd0,   8'd255);
		else if (t_s1 < T_25)  temp_c = rgba(8'd222, 8'd251, 8'd109, 8'd255);
		else if (t_s1 < T_30)  temp_c = rgba(8'd255, 8'd255, 8'd129, 8'd255);
		else if (t_s1 < T_35)  temp_c = rgba(8'd245, 8'd222, 8'd214, 8'd255);
		else if (t_s1 < T_37)  temp_c = rgba(8'd255, 8'd191, 8'd191, 8'd255);
		else                   temp_c = rgba(8'd255, 8'd85,  8'd1,   8'd255);
	end

	always_comb begin
		if (sx_s1 < T_4)       wind_c = CLEAR_WHITE;
		else if (sx_s1 < T_6)  wind_c = rgba(8'd232, 8'd245, 8'd155, 8'd255);
		else if (sx_s1 < T_8)  wind_c = rgba(8'd226, 8'd239, 8'd15,  8'd255);
		else if (sx_s1 < T_12) wind_c = rgba(8'd255, 8'd238, 8'd124, 8'd255);
		else if (sx_s1 < T_14) wind_c = rgba(8'd238, 8'd166, 8'd83,  8'd255);
		else if (sx_s1 < T_18) wind_c = rgba(8'd222, 8'd123, 8'd55,  8'd255);
		else if (sx_s1 < T_21) wind_c = rgba(8'd236, 8'd83,  8'd163, 8'd255);
		else if (sx_s1 < T_25) wind_c = rgba(8'd155, 8'd162, 8'd118, 8'd255);
		else if (sx_s1 < T_29) wind_c = rgba(8'd126, 8'd150, 8'd255, 8'd255);
		else if (sx_s1 < T_33) wind_c = rgba(8'd141, 8'd178, 8'd255, 8'd255);
		else                   wind_c = rgba(8'd180, 8'd201, 8'd255, 8'd255);
	end

	always_comb begin
		case (mode_s1)
			MODE_RADAR: pal_c = radar_color(ridx_c);
			MODE_PRCP:  pal_c = prcp_c;
			MODE_TEMP:  pal_c = temp_c;
			MODE_WIND:  pal_c = wind_c;
			default:    pal_c = CLEAR_BLACK;
		endcase
	end

	// Stage two: fold the gray magnitude modulo 255 (256 is one more than 255).
	logic [12:0] sum1_c;
	logic [8:0]  sum2_c;

	assign sum1_c = 13'(absi_s1 >> 8) + 13'(absi_s1[7:0]);
	assign sum2_c = 9'(sum1_c[12:8]) + 9'(sum1_c[7:0]);

	logic [2:0]    mode_s2;
	sat_band_t     band_s2;
	logic [EW-1:0] e_s2;
	pixel_t        pal_s2;
	logic [8:0]    sum2_s2;
	logic [7:0]    low_s2;
	logic          neg_s2, direct_s2;

	always_ff @(posedge clk) begin
		if (v_s1 && rdy2) begin
			mode_s2   <= mode_s1;
			band_s2   <= band_c;
			e_s2      <= efull_c[EW-1:0];
			pal_s2    <= pal_c;
			sum2_s2   <= sum2_c;
			low_s2    <= absi_s1[7:0];
			neg_s2    <= neg_s1;
			direct_s2 <= direct_s1;
		end
	end

	// Stage three: ramp products by shift and add.
	logic [PW-1:0] ez, p5, p10, p20, dif100, dif255_20, dif255_5;
	logic [7:0]    lo_v, rise_b, ramp20_v, cyan_v, cyan_gb, fade_v;

	assign ez        = PW'(e_s2);
	assign p5        = (ez << 2) + ez;
	assign p10       = p5 << 1;
	assign p20       = p5 << 2;
	assign dif100    = K100 - p10;
	assign dif255_20 = K255 - p20;
	assign dif255_5  = K255 - p5;
	assign lo_v      = 8'd55 + p20[FRAC_BITS +: 8];
	assign rise_b    = dif100[FRAC_BITS +: 8];
	assign ramp20_v  = dif255_20[FRAC_BITS +: 8];
	assign cyan_v    = p10[FRAC_BITS +: 8];
	assign cyan_gb   = cyan_v + 8'd30;
	assign fade_v    = dif255_5[FRAC_BITS +: 8];

	pixel_t sat_c;

	always_comb begin
		unique case (band_s2)
			SB_DARK:  sat_c = rgba(lo_v, lo_v, lo_v, 8'd255);
			SB_RISE:  sat_c = rgba(lo_v, lo_v, rise_b, 8'd255);
			SB_RED:   sat_c = rgba(ramp20_v, 8'd40, 8'd0, 8'd255);
			SB_GREEN: sat_c = rgba(8'd0, ramp20_v, 8'd0, 8'd255);
			SB_BLUE:  sat_c = rgba(8'd0, 8'd0, ramp20_v, 8'd255);
			SB_CYAN:  sat_c = rgba(cyan_v, cyan_gb, cyan_gb, 8'd255);
			SB_FADE:  sat_c = rgba(fade_v, fade_v, fade_v, 8'd255);
			default:  sat_c = CLEAR_BLACK;
		endcase
	end

	// Stage three: finish the remainder and apply the sign of the integer part.
	logic [8:0] m9;
	logic [7:0] gray_v;

	assign m9     = (sum2_s2 >= 9'd255) ? (sum2_s2 - 9'd255) : sum2_s2;
	assign gray_v = direct_s2 ? low_s2 : (neg_s2 ? (8'd0 - m9[7:0]) : m9[7:0]);

	pixel_t out_c, out_s3;

	always_comb begin
		case (mode_s2) inside
			MODE_SAT:                                  out_c = sat_c;
			MODE_RADAR, MODE_PRCP, MODE_TEMP, MODE_WIND: out_c = pal_s2;
			default:                                   out_c = rgba(gray_v, gray_v, gray_v,
			                                                        8'd255);
		endcase
	end

	always_ff @(posedge clk) begin
		if (v_s2 && rdy3) begin
			out_s3 <= out_c;
		end
	end

	assign m_axis_tvalid = v_s3;
	assign m_axis_tdata  = out_s3;

endmodule

`default_nettype wire

@@ design/mpm_checker.sv @@
// Port-level checks of the pseudo-color mapper, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none

module mpm_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_axis_tvalid,
	input wire        s_axis_tready,
	input wire        m_axis_tvalid,
	input wire        m_axis_tready,
	input wire [31:0] m_axis_tdata
);

	// A stalled pixel stays on the bus unchanged.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output pixel changed while stalled");

	// When the receiver takes data the whole pipeline moves, so the input is open.
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tready |-> s_axis_tready)
		else $error("input blocked although the output is draining");

	// Every palette is either fully opaque or fully transparent.
	a_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[31:24] == 8'd0) || (m_axis_tdata[31:24] == 8'd255))
		else $error("partial alpha on output pixel");

	// Transparent pixels are black or white only.
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[31:24] == 8'd0) |->
			(m_axis_tdata[23:0] == 24'h000000) || (m_axis_tdata[23:0] == 24'hFFFFFF))
		else $error("transparent pixel with a color other than black or white");

endmodule

bind meteo_pseudocolor_mapper_core mpm_checker u_mpm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
